FILE: rtl/lpr_pkg.sv
// Shared constants and types for the LRU page replacement block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package lpr_pkg;

  // Default geometry
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Reported frame index is always 3 bits wide
  localparam int FIDX_W = 3;

  // Configuration register
  localparam int              CFG_W          = 4;
  localparam logic [CFG_W-1:0] CFG_FRAMES_RST = 4'd8;

  // APB port geometry: one 32-bit register at byte address 0
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the referenced page
    logic decide;   // tag compare and victim choice
    logic commit;   // update frames and ranks, load the result
  } lpr_cmd_t;

endpackage : lpr_pkg

`default_nettype wire

FILE: rtl/lpr_ctrl.sv
// Sequencing controller for the LRU page replacement block.
// Depends on lpr_pkg (command struct).
`default_nettype none

module lpr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output lpr_pkg::lpr_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result slot can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule : lpr_ctrl

`default_nettype wire

FILE: rtl/lpr_dp.sv
// Datapath: frame tags, valid bits, recency ranks, victim choice, result registers.
// Depends on lpr_pkg (command struct, widths).
`default_nettype none

module lpr_dp #(
  parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lpr_pkg::lpr_cmd_t          cmd_i,
  input  wire logic [lpr_pkg::CFG_W-1:0]  frames_in_use_i,
  input  wire logic [PAGE_BITS-1:0]       page_i,
  output logic                            hit_o,
  output logic [lpr_pkg::FIDX_W-1:0]      frame_index_o,
  output logic                            evicted_valid_o,
  output logic [PAGE_BITS-1:0]            evicted_page_o
);

  localparam int IdxW  = $clog2(FRAMES);
  localparam int RankW = $clog2(FRAMES);
  localparam int FidxW = lpr_pkg::FIDX_W;
  localparam logic [RankW-1:0] RankMax = RankW'(FRAMES - 1);

  typedef enum logic [1:0] {
    KIND_HIT,
    KIND_FILL,
    KIND_EVICT
  } kind_e;

  // Frame state
  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
  logic [FRAMES-1:0]    frame_valid_q;
  logic [RankW-1:0]     rank_q [FRAMES];

  // Per-reference registers
  logic [PAGE_BITS-1:0] page_q;
  kind_e                kind_q, kind_d;
  logic [IdxW-1:0]      sel_q, sel_d;
  logic [RankW-1:0]     old_rank_q;
  logic [PAGE_BITS-1:0] ev_page_q, ev_page_d;

  // Result registers
  logic                 hit_q;
  logic [FidxW-1:0]     fidx_q;
  logic                 evv_q;
  logic [PAGE_BITS-1:0] evp_q;

  logic [FRAMES-1:0] act, match, empty, oldest;
  logic              hit_found, empty_found;
  logic [IdxW-1:0]   hit_idx, empty_idx, old_idx;

  // Active frames, register value clamped to 1..FRAMES
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      act[i] = (i == 0) || (int'(frames_in_use_i) > i);
    end
  end

  // Parallel tag compare, empty search and oldest search
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i]  = act[i] && frame_valid_q[i] && (frame_page_q[i] == page_q);
      empty[i]  = act[i] && !frame_valid_q[i];
      oldest[i] = act[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (act[j] && (j < i) && !(rank_q[i] > rank_q[j])) begin
          oldest[i] = 1'b0;
        end
        if (act[j] && (j > i) && (rank_q[i] < rank_q[j])) begin
          oldest[i] = 1'b0;
        end
      end
    end
  end

  // Lowest set position of each vector
  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_idx     = '0;
    empty_idx   = '0;
    old_idx     = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_found = 1'b1;
        hit_idx   = IdxW'(i);
      end
      if (empty[i]) begin
        empty_found = 1'b1;
        empty_idx   = IdxW'(i);
      end
      if (oldest[i]) begin
        old_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    ev_page_d = '0;
    if (hit_found) begin
      kind_d = KIND_HIT;
      sel_d  = hit_idx;
    end else if (empty_found) begin
      kind_d = KIND_FILL;
      sel_d  = empty_idx;
    end else begin
      kind_d    = KIND_EVICT;
      sel_d     = old_idx;
      ev_page_d = frame_page_q[old_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_i;
    end
    if (cmd_i.decide) begin
      kind_q     <= kind_d;
      sel_q      <= sel_d;
      old_rank_q <= rank_q[sel_d];
      ev_page_q  <= ev_page_d;
    end
    if (cmd_i.commit) begin
      hit_q  <= (kind_q == KIND_HIT);
      fidx_q <= FidxW'(sel_q);
      evv_q  <= (kind_q == KIND_EVICT);
      evp_q  <= ev_page_q;
      if (kind_q != KIND_HIT) begin
        frame_page_q[sel_q] <= page_q;
      end
    end
  end

  // Recency update: selected frame becomes youngest, younger frames age
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (IdxW'(i) == sel_q) begin
          rank_q[i]        <= '0;
          frame_valid_q[i] <= 1'b1;
        end else if (act[i] && frame_valid_q[i] && (rank_q[i] != RankMax) &&
                     ((kind_q == KIND_FILL) || (rank_q[i] < old_rank_q))) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
    end
  end

  assign hit_o           = hit_q;
  assign frame_index_o   = fidx_q;
  assign evicted_valid_o = evv_q;
  assign evicted_page_o  = evp_q;

endmodule : lpr_dp

`default_nettype wire

FILE: rtl/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: APB register, controller, datapath.
// Depends on lpr_pkg, lpr_ctrl and lpr_dp.
`default_nettype none

// Fully associative LRU page frame tracker. Each transfer on the input
// channel carries one page reference; each reference yields exactly one
// result transfer: hit flag, the frame now holding the page, and the page
// evicted on a replacement (evicted_page_o reads 0 when nothing was evicted).
// Once a reference is accepted, the capture step latches the page, the decide
// step registers the parallel tag compare across all frames and the choice of
// victim (lowest empty frame, else the lowest-numbered frame of oldest rank),
// and the commit step, held until the result slot is free, updates tags and
// ranks and loads the result register. The next reference is accepted in the
// cycle after the previous result is loaded, even while that result still
// waits on out_stall_i, so no second reference is taken while one is in
// flight; a held result only delays the commit step. Frame tags have
// no reset; valid bits and ranks clear on reset, so no clearing pass is
// needed. The APB register frames_in_use (byte address 0, bits 3:0, reset 8)
// sets how many frames, counted from frame 0, take part; 0 acts as 1 and
// values above FRAMES act as FRAMES. Write it only while no reference is in
// flight. Frames beyond the active count keep their contents but never hit
// and are never chosen. frame_index_o carries the low 3 bits of the frame
// number.
module lru_page_replacement_top #(
  parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // APB configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lpr_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [lpr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [lpr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  // Reference channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [PAGE_BITS-1:0]            page_i,
  // Result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 hit_o,
  output logic      [lpr_pkg::FIDX_W-1:0]      frame_index_o,
  output logic                                 evicted_valid_o,
  output logic      [PAGE_BITS-1:0]            evicted_page_o
);

  localparam int AddrW = lpr_pkg::APB_ADDR_W;
  localparam int DataW = lpr_pkg::APB_DATA_W;

  logic [lpr_pkg::CFG_W-1:0]     frames_in_use_q;
  logic [lpr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;
  lpr_pkg::lpr_cmd_t             cmd;

  // Word index; the low two address bits select a byte and are ignored
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= lpr_pkg::CFG_FRAMES_RST;
    end else if (cfg_wr && (reg_idx == lpr_pkg::REG_FRAMES_IN_USE)) begin
      frames_in_use_q <= pwdata[lpr_pkg::CFG_W-1:0];
    end
  end

  // Read-back; addresses past the register list read as zero
  always_comb begin
    unique case (reg_idx)
      lpr_pkg::REG_FRAMES_IN_USE: prdata = DataW'(frames_in_use_q);
      default:                    prdata = '0;
    endcase
  end

  lpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .frames_in_use_i (frames_in_use_q),
    .page_i          (page_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o)
  );

endmodule : lru_page_replacement_top

`default_nettype wire

FILE: rtl/lpr_checker.sv
// Port-level checks for the LRU page replacement top level, bound to it.
// Depends on lpr_pkg and lru_page_replacement_top.
`default_nettype none

module lpr_checker #(
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       hit_o,
  input wire logic [lpr_pkg::FIDX_W-1:0] frame_index_o,
  input wire logic                       evicted_valid_o,
  input wire logic [PAGE_BITS-1:0]       evicted_page_o
);

  // One reference in flight: an accepted transfer blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("hit reported with eviction");

  // Without an eviction the evicted page reads zero
  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> (evicted_page_o == '0))
    else $error("evicted page nonzero without eviction");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(hit_o) && $stable(frame_index_o) &&
      $stable(evicted_valid_o) && $stable(evicted_page_o))
    else $error("stalled result changed");

endmodule : lpr_checker

bind lru_page_replacement_top lpr_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_lpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .hit_o           (hit_o),
  .frame_index_o   (frame_index_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o)
);

`default_nettype wire
